/* hw/rtl/sorted_attribute_table_core_macros.svh */
// Assertion helpers used by the checker file.
`ifndef SORTED_ATTRIBUTE_TABLE_CORE_MACROS_SVH
`define SORTED_ATTRIBUTE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sat_pkg.sv */
package sat_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_OK    = 3'd0,
    STAT_DUP   = 3'd1,
    STAT_FULL  = 3'd2,
    STAT_MISS  = 3'd3,
    STAT_RANGE = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]  location;
    logic [3:0]  usage;
    logic [7:0]  usage_index;
    logic [31:0] payload;
  } rec_t;

  // Query token that walks down the cell chain.
  typedef struct packed {
    opcode_t    op;
    rec_t       rec;
    logic [3:0] read_index;
    logic       hit;
    rec_t       hit_rec;
  } tok_t;

endpackage

/* hw/rtl/sat_in_if.sv */
interface sat_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  location;
  logic [3:0]  usage;
  logic [7:0]  usage_index;
  logic [31:0] payload;
  logic [3:0]  read_index;

  modport source (
    output valid, opcode, location, usage, usage_index, payload, read_index,
    input  ready
  );

  modport sink (
    input  valid, opcode, location, usage, usage_index, payload, read_index,
    output ready
  );
endinterface

/* hw/rtl/sat_out_if.sv */
interface sat_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  found_index;
  logic [7:0]  out_location;
  logic [3:0]  out_usage;
  logic [7:0]  out_usage_index;
  logic [31:0] out_payload;
  logic [4:0]  entry_count;

  modport source (
    output valid, status, found_index, out_location, out_usage, out_usage_index,
           out_payload, entry_count,
    input  ready
  );

  modport sink (
    input  valid, status, found_index, out_location, out_usage, out_usage_index,
           out_payload, entry_count,
    output ready
  );
endinterface

/* hw/rtl/sat_cell.sv */
module sat_cell #(
  parameter int IDX = 0,
  parameter int IW  = 4,
  parameter int CW  = 5
) (
  input  logic            clk,
  input  logic            adv,
  input  logic [CW-1:0]   fill,
  input  logic            wr_en,
  input  logic [CW-1:0]   wr_slot,
  input  sat_pkg::rec_t   wr_rec,
  input  sat_pkg::rec_t   prev_rec,
  input  sat_pkg::tok_t   tok_i,
  input  logic [IW-1:0]   hidx_i,
  input  logic [CW-1:0]   slot_i,
  output sat_pkg::tok_t   tok_o,
  output logic [IW-1:0]   hidx_o,
  output logic [CW-1:0]   slot_o,
  output sat_pkg::rec_t   rec_o
);

  sat_pkg::rec_t rec_r;
  sat_pkg::tok_t tok_r, tok_nxt;
  logic [IW-1:0] hidx_r, hidx_nxt;
  logic [CW-1:0] slot_r, slot_nxt;
  logic          valid, key_m, rd_m, match;

  assign valid = (CW'(IDX) < fill);
  assign key_m = valid && (rec_r.usage == tok_i.rec.usage)
                       && (rec_r.usage_index == tok_i.rec.usage_index);
  assign rd_m  = valid && ({28'd0, tok_i.read_index} == 32'(IDX));
  assign match = (tok_i.op == sat_pkg::OP_READ) ? rd_m : key_m;

  always_comb begin
    tok_nxt  = tok_i;
    hidx_nxt = hidx_i;
    // first match wins; later cells leave it alone
    if (!tok_i.hit && match) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_rec = rec_r;
      hidx_nxt        = IW'(IDX);
    end
    // table is sorted, so the slot is the count of held records at or below
    slot_nxt = slot_i + CW'(valid && (rec_r.location <= tok_i.rec.location));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r  <= tok_nxt;
      hidx_r <= hidx_nxt;
      slot_r <= slot_nxt;
    end
  end

  // insert: cells above the slot take the record of the neighbor below, new record at the slot
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (CW'(IDX) == wr_slot) begin
        rec_r <= wr_rec;
      end else if ((CW'(IDX) > wr_slot) && (CW'(IDX) <= fill)) begin
        rec_r <= prev_rec;
      end
    end
  end

  assign tok_o  = tok_r;
  assign hidx_o = hidx_r;
  assign slot_o = slot_r;
  assign rec_o  = rec_r;

endmodule

/* hw/rtl/sorted_attribute_table_core.sv */
// Channel | Dir | Handshake              | Payload
// in_ch   | in  | valid/ready, sink      | opcode, location, usage, usage_index,
//         |     |                        | payload, read_index
// out_ch  | out | valid/ready, source    | status, found_index, out_location, out_usage,
//         |     |                        | out_usage_index, out_payload, entry_count
//
// Result registered once the token has left the last cell, one cell a cycle;
// the next accept waits until the state is back to idle, so one transaction walks at a time.
// An insert shifts the records above its slot in the cycle its result is registered.
// Reset (rst_n, synchronous) clears the count and handshake state; records stay undefined.
// A new transaction is taken while a result still waits in the output register;
// its result is held back in the last cell until that one is taken.
module sorted_attribute_table_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sat_in_if.sink     in_ch,
  sat_out_if.source  out_ch
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] fill_r, fill_nxt;

  sat_pkg::tok_t tok  [0:MAX_ENTRIES];
  logic [IW-1:0] hidx [0:MAX_ENTRIES];
  logic [CW-1:0] slot [0:MAX_ENTRIES];
  sat_pkg::rec_t recs [0:MAX_ENTRIES-1];
  sat_pkg::rec_t prev [0:MAX_ENTRIES-1];

  logic          accept, done, out_free, fin, adv, wr_en;
  sat_pkg::tok_t last;

  logic            out_valid_r;
  sat_pkg::status_t res_status, status_r;
  logic [3:0]      res_idx, idx_r;
  sat_pkg::rec_t   res_rec, rec_r;
  logic [4:0]      res_cnt, cnt_out_r;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign done        = (state_r == ST_WALK) && (cnt_r == IW'(MAX_ENTRIES - 1));
  assign out_free    = !out_valid_r || out_ch.ready;
  assign fin         = done && out_free;
  assign adv         = accept || ((state_r == ST_WALK) && !done);

  always_comb begin
    tok[0].op                  = sat_pkg::opcode_t'(in_ch.opcode);
    tok[0].rec.location        = in_ch.location;
    tok[0].rec.usage           = in_ch.usage;
    tok[0].rec.usage_index     = in_ch.usage_index;
    tok[0].rec.payload         = in_ch.payload;
    tok[0].read_index          = in_ch.read_index;
    tok[0].hit                 = 1'b0;
    tok[0].hit_rec             = '0;
  end
  assign hidx[0] = '0;
  assign slot[0] = '0;
  assign last    = tok[MAX_ENTRIES];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev[g] = last.rec;
    end else begin : g_rest
      assign prev[g] = recs[g-1];
    end

    sat_cell #(.IDX(g), .IW(IW), .CW(CW)) u_cell (
      .clk      (clk),
      .adv      (adv),
      .fill     (fill_r),
      .wr_en    (wr_en),
      .wr_slot  (slot[MAX_ENTRIES]),
      .wr_rec   (last.rec),
      .prev_rec (prev[g]),
      .tok_i    (tok[g]),
      .hidx_i   (hidx[g]),
      .slot_i   (slot[g]),
      .tok_o    (tok[g+1]),
      .hidx_o   (hidx[g+1]),
      .slot_o   (slot[g+1]),
      .rec_o    (recs[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WALK;
          cnt_nxt   = '0;
        end
      end
      ST_WALK: begin
        if (fin) begin
          state_nxt = ST_IDLE;
        end else if (!done) begin
          cnt_nxt = cnt_r + IW'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result of the token that left the last cell
  always_comb begin
    res_status = sat_pkg::STAT_OK;
    res_idx    = '0;
    res_rec    = '0;
    fill_nxt   = fill_r;
    wr_en      = 1'b0;
    case (last.op)
      sat_pkg::OP_CLEAR: begin
        fill_nxt = '0;
      end
      sat_pkg::OP_INSERT: begin
        if (last.hit) begin
          res_status = sat_pkg::STAT_DUP;
        end else if (fill_r == CW'(MAX_ENTRIES)) begin
          res_status = sat_pkg::STAT_FULL;
        end else begin
          res_idx  = 4'(slot[MAX_ENTRIES]);
          res_rec  = last.rec;
          fill_nxt = fill_r + CW'(1);
          wr_en    = fin;
        end
      end
      sat_pkg::OP_LOOKUP: begin
        if (last.hit) begin
          res_idx = 4'(hidx[MAX_ENTRIES]);
          res_rec = last.hit_rec;
        end else begin
          res_status = sat_pkg::STAT_MISS;
        end
      end
      sat_pkg::OP_READ: begin
        if (last.hit) begin
          res_idx = 4'(hidx[MAX_ENTRIES]);
          res_rec = last.hit_rec;
        end else begin
          res_status = sat_pkg::STAT_RANGE;
        end
      end
      default: res_status = sat_pkg::STAT_OK;
    endcase
    res_cnt = 5'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (fin) begin
        fill_r      <= fill_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status_r  <= res_status;
      idx_r     <= res_idx;
      rec_r     <= res_rec;
      cnt_out_r <= res_cnt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.found_index     = idx_r;
  assign out_ch.out_location    = rec_r.location;
  assign out_ch.out_usage       = rec_r.usage;
  assign out_ch.out_usage_index = rec_r.usage_index;
  assign out_ch.out_payload     = rec_r.payload;
  assign out_ch.entry_count     = cnt_out_r;

endmodule

/* hw/rtl/sat_checker.sv */
`include "sorted_attribute_table_core_macros.svh"

module sat_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [3:0]  found_index,
  input logic [7:0]  out_location,
  input logic [3:0]  out_usage,
  input logic [7:0]  out_usage_index,
  input logic [31:0] out_payload,
  input logic [4:0]  entry_count
);

  // one transaction in the chain at a time
  `SAT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "accepted back to back")

  `SAT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(found_index) && $stable(out_payload)
    && $stable(entry_count), "stalled result changed")

  `SAT_ASSERT_NOW(a_status_code, out_valid,
    status <= sat_pkg::STAT_RANGE, "status code out of range")

  // every failing status returns an empty record
  `SAT_ASSERT_NOW(a_fail_empty, out_valid && (status != sat_pkg::STAT_OK),
    found_index == 4'd0 && out_location == 8'd0 && out_usage == 4'd0
    && out_usage_index == 8'd0 && out_payload == 32'd0, "failed result not empty")

endmodule

bind sorted_attribute_table_core sat_checker u_sat_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .status          (out_ch.status),
  .found_index     (out_ch.found_index),
  .out_location    (out_ch.out_location),
  .out_usage       (out_ch.out_usage),
  .out_usage_index (out_ch.out_usage_index),
  .out_payload     (out_ch.out_payload),
  .entry_count     (out_ch.entry_count)
);

/* verif/tb_sorted_attribute_table_core.sv */
module tb_sorted_attribute_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENTRIES = 16;
  localparam int LATENCY     = MAX_ENTRIES + 1;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_PHASES  = 5;
  localparam int PRESSURE_PHASE = 4;

  typedef struct packed {
    sat_pkg::opcode_t op;
    sat_pkg::rec_t    rec;
    logic [3:0]       read_index;
  } table_op_t;

  typedef struct packed {
    sat_pkg::status_t status;
    logic [3:0]       found_index;
    sat_pkg::rec_t    rec;
    logic [4:0]       entry_count;
  } table_result_t;

  // typed = 1: result written out by hand; echo = 1: record fields repeat the input record
  typedef struct packed {
    sat_pkg::opcode_t op;
    logic [7:0]       location;
    logic [3:0]       usage;
    logic [7:0]       usage_index;
    logic [31:0]      payload;
    logic [3:0]       read_index;
    logic             typed;
    sat_pkg::status_t status;
    logic [3:0]       found_index;
    logic             echo;
    logic [4:0]       entry_count;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [27] = '{
    '{sat_pkg::OP_READ,   8'd0,   4'd0,  8'd0,   32'h0000_0000, 4'd0,
      1'b1, sat_pkg::STAT_RANGE, 4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_LOOKUP, 8'd0,   4'd0,  8'd0,   32'h0000_0000, 4'd0,
      1'b1, sat_pkg::STAT_MISS,  4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_CLEAR,  8'd255, 4'd15, 8'd255, 32'hFFFF_FFFF, 4'd15,
      1'b1, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd128, 4'd1,  8'd1,   32'hDEAD_BEEF, 4'd0,
      1'b1, sat_pkg::STAT_OK,    4'd0, 1'b1, 5'd1},
    '{sat_pkg::OP_INSERT, 8'd0,   4'd15, 8'd255, 32'hFFFF_FFFF, 4'd0,
      1'b1, sat_pkg::STAT_OK,    4'd0, 1'b1, 5'd2},
    '{sat_pkg::OP_INSERT, 8'd255, 4'd0,  8'd0,   32'h0000_0000, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    // same location as an entry already held: must land after it
    '{sat_pkg::OP_INSERT, 8'd128, 4'd2,  8'd1,   32'h1234_5678, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd7,   4'd1,  8'd1,   32'h5555_AAAA, 4'd0,
      1'b1, sat_pkg::STAT_DUP,   4'd0, 1'b0, 5'd4},
    '{sat_pkg::OP_LOOKUP, 8'd0,   4'd15, 8'd255, 32'h0000_0000, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_LOOKUP, 8'd0,   4'd3,  8'd3,   32'h0000_0000, 4'd0,
      1'b1, sat_pkg::STAT_MISS,  4'd0, 1'b0, 5'd4},
    '{sat_pkg::OP_READ,   8'd0,   4'd0,  8'd0,   32'h0000_0000, 4'd4,
      1'b1, sat_pkg::STAT_RANGE, 4'd0, 1'b0, 5'd4},
    '{sat_pkg::OP_INSERT, 8'd64,  4'd4,  8'd4,   32'hA5A5_0004, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd200, 4'd5,  8'd5,   32'h0F0F_0005, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd0,   4'd6,  8'd6,   32'h8000_0006, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd255, 4'd7,  8'd7,   32'h7FFF_0007, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd17,  4'd8,  8'd8,   32'h0000_0008, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd128, 4'd9,  8'd9,   32'h1111_0009, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd90,  4'd10, 8'd10,  32'h2222_000A, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd3,   4'd11, 8'd11,  32'h3333_000B, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd250, 4'd12, 8'd12,  32'h4444_000C, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd128, 4'd13, 8'd13,  32'h5555_000D, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd42,  4'd14, 8'd14,  32'h6666_000E, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd0,   4'd15, 8'd15,  32'h7777_000F, 4'd0,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_INSERT, 8'd10,  4'd3,  8'd3,   32'h0BAD_0BAD, 4'd0,
      1'b1, sat_pkg::STAT_FULL,  4'd0, 1'b0, 5'd16},
    // duplicate wins over full
    '{sat_pkg::OP_INSERT, 8'd10,  4'd15, 8'd255, 32'h0BAD_0BAD, 4'd0,
      1'b1, sat_pkg::STAT_DUP,   4'd0, 1'b0, 5'd16},
    '{sat_pkg::OP_READ,   8'd0,   4'd0,  8'd0,   32'h0000_0000, 4'd15,
      1'b0, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0},
    '{sat_pkg::OP_CLEAR,  8'd0,   4'd0,  8'd0,   32'h0000_0000, 4'd0,
      1'b1, sat_pkg::STAT_OK,    4'd0, 1'b0, 5'd0}
  };

  localparam int PHASE_ITEMS [NUM_PHASES] = '{200, 200, 200, 250, 80};
  localparam int SEND_IDLE   [NUM_PHASES] = '{0, 72, 0, 26, 0};
  localparam int RECV_STALL  [NUM_PHASES] = '{0, 0, 72, 26, 26};

  logic clk;
  logic rst_n;

  sat_in_if  in_ch ();
  sat_out_if out_ch ();

  sorted_attribute_table_core #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // predictor state
  sat_pkg::rec_t model_recs [MAX_ENTRIES];
  int            model_fill;

  table_result_t table_replies_due [$];
  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

  function automatic int find_key(input logic [3:0] usage, input logic [7:0] usage_index);
    for (int i = 0; i < model_fill; i++) begin
      if (model_recs[i].usage == usage && model_recs[i].usage_index == usage_index) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic table_result_t predict_table_op(input table_op_t t);
    table_result_t r;
    int hit;
    int slot;
    r = '0;
    r.status = sat_pkg::STAT_OK;
    case (t.op)
      sat_pkg::OP_CLEAR: begin
        model_fill = 0;
      end
      sat_pkg::OP_INSERT: begin
        hit = find_key(t.rec.usage, t.rec.usage_index);
        if (hit >= 0) begin
          r.status = sat_pkg::STAT_DUP;
        end else if (model_fill >= MAX_ENTRIES) begin
          r.status = sat_pkg::STAT_FULL;
        end else begin
          // shift larger locations up; equal ones stay below the new record
          slot = model_fill;
          while (slot > 0 && model_recs[slot-1].location > t.rec.location) begin
            model_recs[slot] = model_recs[slot-1];
            slot--;
          end
          model_recs[slot] = t.rec;
          model_fill++;
          r.found_index = 4'(slot);
          r.rec = t.rec;
        end
      end
      sat_pkg::OP_LOOKUP: begin
        hit = find_key(t.rec.usage, t.rec.usage_index);
        if (hit >= 0) begin
          r.found_index = 4'(hit);
          r.rec = model_recs[hit];
        end else begin
          r.status = sat_pkg::STAT_MISS;
        end
      end
      default: begin
        if (int'(t.read_index) < model_fill) begin
          r.found_index = t.read_index;
          r.rec = model_recs[t.read_index];
        end else begin
          r.status = sat_pkg::STAT_RANGE;
        end
      end
    endcase
    r.entry_count = 5'(model_fill);
    return r;
  endfunction

  // mostly well-formed traffic aimed at held keys and positions, some raw noise
  function automatic table_op_t random_table_op();
    table_op_t t;
    int p;
    int k;
    t.op                = sat_pkg::opcode_t'(2'($urandom_range(3)));
    t.rec.location      = 8'($urandom_range(255));
    t.rec.usage         = 4'($urandom_range(15));
    t.rec.usage_index   = 8'($urandom_range(255));
    t.rec.payload       = $urandom;
    t.read_index        = 4'($urandom_range(15));
    p = $urandom_range(99);
    if (p < 4) begin
      t.op = sat_pkg::OP_CLEAR;
    end else if (p < 46) begin
      t.op = sat_pkg::OP_INSERT;
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(2))
          0: t.rec.location = 8'd0;
          1: t.rec.location = 8'd255;
          default: begin
            if (model_fill > 0) begin
              t.rec.location = model_recs[$urandom_range(model_fill - 1)].location;
            end
          end
        endcase
      end
      if (model_fill > 0 && $urandom_range(4) == 0) begin
        k = $urandom_range(model_fill - 1);
        t.rec.usage       = model_recs[k].usage;
        t.rec.usage_index = model_recs[k].usage_index;
      end
    end else if (p < 76) begin
      t.op = sat_pkg::OP_LOOKUP;
      if (model_fill > 0 && $urandom_range(99) < 65) begin
        k = $urandom_range(model_fill - 1);
        t.rec.usage       = model_recs[k].usage;
        t.rec.usage_index = model_recs[k].usage_index;
      end
    end else if (p < 95) begin
      t.op = sat_pkg::OP_READ;
      if (model_fill > 0 && $urandom_range(9) < 7) begin
        t.read_index = 4'($urandom_range(model_fill - 1));
      end
    end
    return t;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic issue_op(input table_op_t t, input bit typed_exp,
                          input table_result_t typed_res);
    table_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= t.op;
    in_ch.location    <= t.rec.location;
    in_ch.usage       <= t.rec.usage;
    in_ch.usage_index <= t.rec.usage_index;
    in_ch.payload     <= t.rec.payload;
    in_ch.read_index  <= t.read_index;
    do @(posedge clk); while (!in_ch.ready);
    res = predict_table_op(t);
    table_replies_due.push_back(typed_exp ? typed_res : res);
    @(negedge clk);
  endtask

  // receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (table_replies_due.size() == 0) begin
        flag_mismatch($sformatf("result transaction with nothing pending, status %0d",
                                out_ch.status));
      end else begin
        want = table_replies_due.pop_front();
        compare_field("status", 32'(out_ch.status), 32'(want.status));
        compare_field("found_index", 32'(out_ch.found_index), 32'(want.found_index));
        compare_field("out_location", 32'(out_ch.out_location), 32'(want.rec.location));
        compare_field("out_usage", 32'(out_ch.out_usage), 32'(want.rec.usage));
        compare_field("out_usage_index", 32'(out_ch.out_usage_index),
                      32'(want.rec.usage_index));
        compare_field("out_payload", out_ch.out_payload, want.rec.payload);
        compare_field("entry_count", 32'(out_ch.entry_count), 32'(want.entry_count));
      end
    end
  end

  // sender and sequencing
  initial begin
    table_op_t     cmd;
    table_result_t typed_res;
    directed_row_t row;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = sat_pkg::OP_CLEAR;
    in_ch.location    = '0;
    in_ch.usage       = '0;
    in_ch.usage_index = '0;
    in_ch.payload     = '0;
    in_ch.read_index  = '0;
    hold_req          = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    mismatch_count    = 0;
    model_fill        = 0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      model_recs[i] = '0;
    end
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      cmd.op                = row.op;
      cmd.rec.location      = row.location;
      cmd.rec.usage         = row.usage;
      cmd.rec.usage_index   = row.usage_index;
      cmd.rec.payload       = row.payload;
      cmd.read_index        = row.read_index;
      typed_res.status      = row.status;
      typed_res.found_index = row.found_index;
      typed_res.rec         = row.echo ? cmd.rec : '0;
      typed_res.entry_count = row.entry_count;
      issue_op(cmd, row.typed, typed_res);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = SEND_IDLE[ph];
      recv_stall_pct = RECV_STALL[ph];
      // long receiver hold-off while the sender keeps offering back to back
      if (ph == PRESSURE_PHASE) begin
        hold_req = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
        issue_op(random_table_op(), 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;

    while (table_replies_due.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
